// File: rtl/kes_pkg.sv
// Package for the Kepler equation solver: constants, sequencer states, CORDIC arc table.
`timescale 1ns / 1ps
package kes_pkg;

   localparam int ANGLE_BITS_DEF   = 32;
   localparam int MAX_ITER_DEF     = 16;
   localparam int BISECT_STEPS_DEF = 32;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 50;   // x/y datapath width
   localparam int CORDIC_ZW    = 34;   // angle accumulator width
   localparam int ITER_W       = 7;
   localparam int MUL_AW       = 34;
   localparam int MUL_BW       = 32;
   localparam int MUL_PW       = MUL_AW + MUL_BW;
   localparam int ROOT_W       = 34;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 50'sd652032874;
   localparam logic signed [MUL_AW-1:0]   INV_TWO_PI_Q32  = 34'sd683565276;
   localparam logic signed [CORDIC_ZW-1:0] QUARTER_TURN32 = 34'sd1073741824;
   localparam logic signed [CORDIC_ZW-1:0] HALF_TURN32    = 34'sd2147483648;
   localparam logic signed [CORDIC_W:0]    ONE_Q30        = 51'sd1073741824;

   // register indexes
   localparam logic [1:0] REG_ECC  = 2'd0;
   localparam logic [1:0] REG_MODE = 2'd1;
   localparam logic [1:0] REG_TOL  = 2'd2;
   localparam logic [15:0] TOL_RESET = 16'd684;

   localparam logic MODE_NEWTON = 1'b0;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ROT_START,
      S_ROT_WAIT,
      S_MUL_ES,
      S_MUL_INV,
      S_MUL_EC,
      S_BIS_UPD,
      S_DIV_START,
      S_DIV_WAIT,
      S_NEW_UPD,
      S_FROT_START,
      S_FROT_WAIT,
      S_SQP_START,
      S_SQP_WAIT,
      S_SQM_START,
      S_SQM_WAIT,
      S_MUL_Y,
      S_MUL_X,
      S_VEC_START,
      S_VEC_WAIT,
      S_DONE
   } state_type;

   // arctangent of 2^-i in 32-bit binary angle units
   function automatic logic signed [CORDIC_ZW-1:0] kes_arc(input logic [4:0] idx);
      logic signed [CORDIC_ZW-1:0] a;
      case (idx)
         5'd0:  a = 34'sd536870912;
         5'd1:  a = 34'sd316933406;
         5'd2:  a = 34'sd167458907;
         5'd3:  a = 34'sd85004756;
         5'd4:  a = 34'sd42667331;
         5'd5:  a = 34'sd21354465;
         5'd6:  a = 34'sd10679838;
         5'd7:  a = 34'sd5340245;
         5'd8:  a = 34'sd2670163;
         5'd9:  a = 34'sd1335087;
         5'd10: a = 34'sd667544;
         5'd11: a = 34'sd333772;
         5'd12: a = 34'sd166886;
         5'd13: a = 34'sd83443;
         5'd14: a = 34'sd41721;
         5'd15: a = 34'sd20861;
         5'd16: a = 34'sd10430;
         5'd17: a = 34'sd5215;
         5'd18: a = 34'sd2608;
         5'd19: a = 34'sd1304;
         5'd20: a = 34'sd652;
         5'd21: a = 34'sd326;
         5'd22: a = 34'sd163;
         5'd23: a = 34'sd81;
         5'd24: a = 34'sd41;
         5'd25: a = 34'sd20;
         5'd26: a = 34'sd10;
         5'd27: a = 34'sd5;
         5'd28: a = 34'sd3;
         5'd29: a = 34'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// File: rtl/kes_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation (sin/cos) or vectoring (atan2).
`timescale 1ns / 1ps
module kes_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 vec,
   input  logic [31:0]                          ang,
   input  logic signed [kes_pkg::CORDIC_W-1:0]  xin,
   input  logic signed [kes_pkg::CORDIC_W-1:0]  yin,
   output logic                                 done,
   output logic signed [kes_pkg::CORDIC_W-1:0]  cos_out,
   output logic signed [kes_pkg::CORDIC_W-1:0]  sin_out,
   output logic signed [kes_pkg::CORDIC_ZW-1:0] z_out
);
   localparam int W  = kes_pkg::CORDIC_W;
   localparam int ZW = kes_pkg::CORDIC_ZW;

   logic signed [W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [4:0]           i_ff, i_in;
   logic                 busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in, vec_ff, vec_in;
   logic signed [W-1:0]  xs, ys;
   logic signed [ZW-1:0] za, arc;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0; flip_in = flip_ff; vec_in = vec_ff;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      arc = kes_pkg::kes_arc(i_ff);
      za = ZW'($signed(ang));
      if (start) begin
         busy_in = 1'b1;
         i_in = '0;
         vec_in = vec;
         flip_in = 1'b0;
         if (vec) begin
            // pre-rotate the left half plane by a quarter turn
            if (xin < 0) begin
               if (yin >= 0) begin
                  x_in = yin; y_in = -xin; z_in = kes_pkg::QUARTER_TURN32;
               end else begin
                  x_in = -yin; y_in = xin; z_in = -kes_pkg::QUARTER_TURN32;
               end
            end else begin
               x_in = xin; y_in = yin; z_in = '0;
            end
         end else begin
            x_in = kes_pkg::CORDIC_GAIN_Q30;
            y_in = '0;
            z_in = za;
            if (za > kes_pkg::QUARTER_TURN32) begin
               z_in = za - kes_pkg::HALF_TURN32; flip_in = 1'b1;
            end else if (za < -kes_pkg::QUARTER_TURN32) begin
               z_in = za + kes_pkg::HALF_TURN32; flip_in = 1'b1;
            end
         end
      end else if (busy_ff) begin
         if (vec_ff) begin
            if (y_ff > 0) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + arc;
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - arc;
            end
         end else begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - arc;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + arc;
            end
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(kes_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      flip_ff <= flip_in; vec_ff <= vec_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign z_out   = z_ff;
endmodule

// File: rtl/kes_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module kes_div #(
   parameter int NUM_W = 62
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [31:0]      den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [31:0]      rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [32:0]      trial;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, q_ff[NUM_W-1]};
      if (start) begin
         q_in = num; rem_in = '0; den_in = den; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// File: rtl/kes_isqrt.sv
// Bit-serial integer floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module kes_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [kes_pkg::ROOT_W-1:0]        rad,
   output logic                              done,
   output logic [kes_pkg::ROOT_W-1:0]        root
);
   localparam int W = kes_pkg::ROOT_W;

   logic [W-1:0] v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic [W-1:0] rb;
   logic         busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      v_in = v_ff; r_in = r_ff; b_in = b_ff; busy_in = busy_ff; done_in = 1'b0;
      rb = r_ff + b_ff;
      if (start) begin
         v_in = rad; r_in = '0; b_in = W'(1) << (W - 2); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= rb) begin
            v_in = v_ff - rb;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in; r_ff <= r_in; b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff;
endmodule

// File: rtl/kepler_equation_solver_top.sv
// Newton mode runs at most MAX_ITER iterations, then the true-anomaly tail.
// Bisection runs BISECT_STEPS steps, then the same tail.
// One item at a time; the shared CORDIC and the bit-serial divider set the rate.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active high) clears the sequencer and loads register defaults.
`timescale 1ns / 1ps
module kepler_equation_solver_top #(
   parameter int ANGLE_BITS   = kes_pkg::ANGLE_BITS_DEF,
   parameter int MAX_ITER     = kes_pkg::MAX_ITER_DEF,
   parameter int BISECT_STEPS = kes_pkg::BISECT_STEPS_DEF,
   localparam int REQ_W = ((ANGLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * ANGLE_BITS + 8 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // mean_anomaly
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // eccentric_anomaly, true_anomaly, converged, iterations
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int AB     = ANGLE_BITS;
   localparam int NW     = AB + 30;
   localparam int ESU_SH = 62 - AB;
   localparam int IW     = kes_pkg::ITER_W;
   localparam int CW     = kes_pkg::CORDIC_W;
   localparam int ZW     = kes_pkg::CORDIC_ZW;
   localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

   // ---------------- configuration registers ----------------
   logic [15:0] ecc_ff, tol_ff;
   logic        mode_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ecc_ff  <= '0;
         mode_ff <= kes_pkg::MODE_NEWTON;
         tol_ff  <= kes_pkg::TOL_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            kes_pkg::REG_ECC:  ecc_ff  <= csr_pwdata[15:0];
            kes_pkg::REG_MODE: mode_ff <= csr_pwdata[0];
            kes_pkg::REG_TOL:  tol_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         kes_pkg::REG_ECC:  csr_prdata = {16'd0, ecc_ff};
         kes_pkg::REG_MODE: csr_prdata = {31'd0, mode_ff};
         kes_pkg::REG_TOL:  csr_prdata = {16'd0, tol_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer state and datapath registers ----------------
   kes_pkg::state_type state_ff, state_in;

   logic [AB-1:0] m_ff, ea_ff, mm_ff, step_ff, esu_ff, mag_ff;
   logic          neg_ff, fold_ff, bis_ff;
   logic [IW-1:0] iters_ff;
   logic          conv_ff;
   logic signed [kes_pkg::MUL_AW-1:0] s_ff, c_ff;
   logic signed [kes_pkg::MUL_PW-1:0] prod_ff, prod_in;
   logic signed [CW-1:0] y_ff;
   logic [17:0]   sp_ff, sm_ff;

   logic [AB-1:0] ea_out_ff, ta_out_ff;
   logic          conv_out_ff, rsp_valid_ff;
   logic [IW-1:0] iters_out_ff;

   logic req_acc, rsp_acc, out_load;
   assign req_tready = (state_ff == kes_pkg::S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_valid_ff & rsp_tready;
   assign out_load   = (state_ff == kes_pkg::S_DONE) & (~rsp_valid_ff | rsp_tready);

   // ---------------- shared units ----------------
   logic              cor_start, cor_vec, cor_done;
   logic [31:0]       cor_ang;
   logic signed [CW-1:0] cor_x, cor_y, cor_cos, cor_sin;
   logic signed [ZW-1:0] cor_z;
   logic              div_start, div_done;
   logic [NW-1:0]     div_num, div_quot;
   logic [31:0]       div_den;
   logic              sq_start, sq_done;
   logic [kes_pkg::ROOT_W-1:0] sq_rad, sq_root;

   kes_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .vec(cor_vec), .ang(cor_ang),
      .xin(cor_x), .yin(cor_y), .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin),
      .z_out(cor_z)
   );

   kes_div #(.NUM_W(NW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot)
   );

   kes_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .rad(sq_rad), .done(sq_done),
      .root(sq_root)
   );

   // ---------------- combinational datapath ----------------
   logic [AB+31:0] turn_wide;
   logic [AB-1:0]  ang_src;
   logic [AB-1:0]  d_val, mag_val, st_val, ea_step, ea_fin;
   logic signed [kes_pkg::MUL_PW-1:0] esu_sh;
   logic signed [CW:0] den_full;
   logic [31:0]    den_val;
   logic signed [AB+1:0] diff;
   logic [IW-1:0]  iters_nx;
   logic [31+AB:0] ta_wide;
   logic signed [kes_pkg::MUL_AW-1:0] mul_a;
   logic signed [kes_pkg::MUL_BW-1:0] mul_b;

   always_comb begin
      // angle into the CORDIC: cut or widen to a 32-bit turn
      ang_src   = (state_ff == kes_pkg::S_FROT_START) ? (ea_ff >> 1) : ea_ff;
      turn_wide = {ang_src, 32'd0};
      cor_ang   = turn_wide[AB+31 -: 32];

      // e*sin(E) in angle units
      esu_sh = prod_ff >>> ESU_SH;

      // mean anomaly error and its magnitude
      d_val   = m_ff - ea_ff + esu_ff;
      mag_val = d_val[AB-1] ? (AB'(0) - d_val) : d_val;

      // 1 - e*cos(E), never below one LSB
      den_full = kes_pkg::ONE_Q30 - (CW+1)'(prod_ff >>> 16);
      den_val  = (den_full < 1) ? 32'd1 : den_full[31:0];
      div_num  = {mag_val, 30'd0};
      div_den  = den_val;

      // saturated Newton step
      st_val  = (div_quot > NW'(HALF)) ? HALF : div_quot[AB-1:0];
      ea_step = neg_ff ? (ea_ff - st_val) : (ea_ff + st_val);

      // bisection direction
      diff = $signed({2'b00, mm_ff}) - $signed({2'b00, ea_ff})
           + $signed({{2{esu_sh[AB-1]}}, esu_sh[AB-1:0]});
      if (diff > 0)      ea_fin = ea_ff + step_ff;
      else if (diff < 0) ea_fin = ea_ff - step_ff;
      else               ea_fin = ea_ff;

      iters_nx = iters_ff + 1'b1;

      // true anomaly is twice the vectoring angle
      ta_wide = {cor_z[30:0], 1'b0, AB'(0)};
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kes_pkg::S_IDLE:      if (req_acc) state_in = kes_pkg::S_ROT_START;
         kes_pkg::S_ROT_START: state_in = kes_pkg::S_ROT_WAIT;
         kes_pkg::S_ROT_WAIT:  if (cor_done) state_in = kes_pkg::S_MUL_ES;
         kes_pkg::S_MUL_ES:    state_in = kes_pkg::S_MUL_INV;
         kes_pkg::S_MUL_INV:   state_in = bis_ff ? kes_pkg::S_BIS_UPD : kes_pkg::S_MUL_EC;
         kes_pkg::S_MUL_EC:    state_in = kes_pkg::S_DIV_START;
         kes_pkg::S_BIS_UPD:   state_in = (iters_nx == IW'(BISECT_STEPS)) ?
                                          kes_pkg::S_FROT_START : kes_pkg::S_ROT_START;
         kes_pkg::S_DIV_START: state_in = kes_pkg::S_DIV_WAIT;
         kes_pkg::S_DIV_WAIT:  if (div_done) state_in = kes_pkg::S_NEW_UPD;
         kes_pkg::S_NEW_UPD:   state_in = (mag_ff <= AB'(tol_ff) || iters_nx == IW'(MAX_ITER)) ?
                                          kes_pkg::S_FROT_START : kes_pkg::S_ROT_START;
         kes_pkg::S_FROT_START: state_in = kes_pkg::S_FROT_WAIT;
         kes_pkg::S_FROT_WAIT: if (cor_done) state_in = kes_pkg::S_SQP_START;
         kes_pkg::S_SQP_START: state_in = kes_pkg::S_SQP_WAIT;
         kes_pkg::S_SQP_WAIT:  if (sq_done) state_in = kes_pkg::S_SQM_START;
         kes_pkg::S_SQM_START: state_in = kes_pkg::S_SQM_WAIT;
         kes_pkg::S_SQM_WAIT:  if (sq_done) state_in = kes_pkg::S_MUL_Y;
         kes_pkg::S_MUL_Y:     state_in = kes_pkg::S_MUL_X;
         kes_pkg::S_MUL_X:     state_in = kes_pkg::S_VEC_START;
         kes_pkg::S_VEC_START: state_in = kes_pkg::S_VEC_WAIT;
         kes_pkg::S_VEC_WAIT:  if (cor_done) state_in = kes_pkg::S_DONE;
         kes_pkg::S_DONE:      if (out_load) state_in = kes_pkg::S_IDLE;
         default:              state_in = kes_pkg::S_IDLE;
      endcase
   end

   // ---------------- unit controls and multiplier operands ----------------
   always_comb begin
      cor_start = 1'b0; cor_vec = 1'b0; cor_x = prod_ff[CW-1:0]; cor_y = y_ff;
      div_start = 1'b0; sq_start = 1'b0;
      sq_rad = kes_pkg::ROOT_W'({17'h10000 + {1'b0, ecc_ff}, 16'd0});
      mul_a = s_ff;
      mul_b = kes_pkg::MUL_BW'({1'b0, ecc_ff});
      case (state_ff)
         kes_pkg::S_ROT_START, kes_pkg::S_FROT_START: cor_start = 1'b1;
         kes_pkg::S_VEC_START: begin
            cor_start = 1'b1; cor_vec = 1'b1;
         end
         kes_pkg::S_DIV_START: div_start = 1'b1;
         kes_pkg::S_SQP_START: sq_start = 1'b1;
         kes_pkg::S_SQM_START: begin
            sq_start = 1'b1;
            sq_rad = kes_pkg::ROOT_W'({17'h10000 - {1'b0, ecc_ff}, 16'd0});
         end
         kes_pkg::S_MUL_INV: begin
            mul_a = kes_pkg::INV_TWO_PI_Q32;
            mul_b = prod_ff[47:16];
         end
         kes_pkg::S_MUL_EC: mul_a = c_ff;
         kes_pkg::S_MUL_Y:  mul_b = kes_pkg::MUL_BW'({1'b0, sp_ff});
         kes_pkg::S_MUL_X: begin
            mul_a = c_ff;
            mul_b = kes_pkg::MUL_BW'({1'b0, sm_ff});
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kes_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load)     rsp_valid_ff <= 1'b1;
         else if (rsp_acc) rsp_valid_ff <= 1'b0;
      end

      prod_ff <= prod_in;

      case (state_ff)
         kes_pkg::S_IDLE: begin
            if (req_acc) begin
               m_ff     <= req_tdata[AB-1:0];
               bis_ff   <= mode_ff;
               iters_ff <= '0;
               step_ff  <= AB'(1) << (AB - 3);
               fold_ff  <= req_tdata[AB-1:0] > HALF;
               mm_ff    <= (req_tdata[AB-1:0] > HALF) ? (AB'(0) - req_tdata[AB-1:0])
                                                      : req_tdata[AB-1:0];
               ea_ff    <= (mode_ff == kes_pkg::MODE_NEWTON) ? req_tdata[AB-1:0]
                                                             : (AB'(1) << (AB - 2));
            end
         end
         kes_pkg::S_ROT_WAIT, kes_pkg::S_FROT_WAIT: begin
            if (cor_done) begin
               s_ff <= cor_sin[kes_pkg::MUL_AW-1:0];
               c_ff <= cor_cos[kes_pkg::MUL_AW-1:0];
            end
         end
         kes_pkg::S_MUL_EC: esu_ff <= esu_sh[AB-1:0];
         kes_pkg::S_BIS_UPD: begin
            iters_ff <= iters_nx;
            step_ff  <= step_ff >> 1;
            conv_ff  <= 1'b1;
            if (iters_nx == IW'(BISECT_STEPS))
               ea_ff <= fold_ff ? (AB'(0) - ea_fin) : ea_fin;
            else
               ea_ff <= ea_fin;
         end
         kes_pkg::S_DIV_START: begin
            mag_ff <= mag_val;
            neg_ff <= d_val[AB-1];
         end
         kes_pkg::S_NEW_UPD: begin
            ea_ff    <= ea_step;
            iters_ff <= iters_nx;
            conv_ff  <= (mag_ff <= AB'(tol_ff));
         end
         kes_pkg::S_SQP_WAIT: if (sq_done) sp_ff <= sq_root[17:0];
         kes_pkg::S_SQM_WAIT: if (sq_done) sm_ff <= sq_root[17:0];
         kes_pkg::S_MUL_X:    y_ff <= prod_ff[CW-1:0];
         kes_pkg::S_DONE: begin
            if (out_load) begin
               ea_out_ff    <= ea_ff;
               ta_out_ff    <= ta_wide[31+AB -: AB];
               conv_out_ff  <= conv_ff;
               iters_out_ff <= iters_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({iters_out_ff, conv_out_ff, ta_out_ff, ea_out_ff});

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != kes_pkg::S_IDLE)
      else $error("sequencer did not start on accepted beat");

   a_not_converged_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !conv_out_ff) |-> iters_out_ff == IW'(MAX_ITER))
      else $error("unconverged result before iteration limit");

   a_out_load_only_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == kes_pkg::S_DONE)
      else $error("result appeared outside the done state");
`endif
endmodule

// File: verif/kepler_equation_solver_checker.sv
// Checker for the Kepler equation solver: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module kepler_equation_solver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // mean_anomaly
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // eccentric_anomaly, true_anomaly, converged, iterations
   input  logic [71:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          outstanding
);
   localparam int NEWTON_LIMIT = 16;
   localparam int BISECT_COUNT = 32;
   localparam longint GAIN      = 652032874;
   localparam longint INV_2PI   = 683565276;
   localparam longint Q30_ONE   = 64'sd1 <<< 30;
   localparam longint TURN      = 64'sd1 <<< 32;
   localparam longint HALF      = 64'sd1 <<< 31;

   typedef struct packed {
      logic [6:0]  iterations;
      logic        converged;
      logic [31:0] true_anomaly;
      logic [31:0] eccentric_anomaly;
   } anomaly_type;

   localparam longint ARC_TAB [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   logic [15:0] ecc_q;
   logic        mode_q;
   logic [15:0] tol_q;
   anomaly_type anomaly_q[$];

   // rotation CORDIC, Q1.30 sine and cosine
   function automatic void rot_sincos(input logic [31:0] ang, output longint s,
                                      output longint c);
      longint z, x, y, nx;
      bit     flip;
      z = ang[31] ? longint'(ang) - TURN : longint'(ang);
      x = GAIN;
      y = 0;
      flip = 0;
      if (z > Q30_ONE) begin
         z -= HALF;
         flip = 1;
      end else if (z < -Q30_ONE) begin
         z += HALF;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= ARC_TAB[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += ARC_TAB[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // vectoring CORDIC, angle in 32-bit binary units
   function automatic longint vec_angle(input longint yi, input longint xi);
      longint z, t, nx, x, y;
      x = xi;
      y = yi;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = Q30_ONE;
         end else begin
            t = x; x = -y; y = t; z = -Q30_ONE;
         end
      end
      for (int i = 0; i < 30; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); y = y - (x >>> i); z += ARC_TAB[i];
         end else begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= ARC_TAB[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v_in);
      longint unsigned v, r, b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // e*sin(E) in binary angle units
   function automatic longint ecc_sin(input longint s);
      longint p;
      p = (longint'(ecc_q) * s) >>> 16;
      return (p * INV_2PI) >>> 30;
   endfunction

   function automatic longint unsigned sat_div(input longint unsigned a,
                                               input longint unsigned d);
      longint unsigned q, r, res;
      q = a / d;
      r = a % d;
      if (q > (HALF >> 30)) return HALF;
      res = (q << 30) + ((r << 30) / d);
      return res > HALF ? HALF : res;
   endfunction

   function automatic anomaly_type solve_kepler(input logic [31:0] m);
      anomaly_type    res;
      logic [31:0]    ea, d;
      longint         s, c, dm, den, mm, e0, stp, diff, y, x, z;
      longint unsigned mag, st, sp, sm;
      int             iters;
      bit             conv, fold;
      iters = 0;
      conv = 0;
      if (mode_q == kes_pkg::MODE_NEWTON) begin
         ea = m;
         while (iters < NEWTON_LIMIT) begin
            rot_sincos(ea, s, c);
            d = m - ea + 32'(ecc_sin(s));
            dm = longint'($signed(d));
            den = Q30_ONE - ((longint'(ecc_q) * c) >>> 16);
            if (den < 1) den = 1;
            mag = dm < 0 ? -dm : dm;
            st = sat_div(mag, den);
            ea = dm < 0 ? ea - 32'(st) : ea + 32'(st);
            iters++;
            if (mag <= tol_q) begin
               conv = 1;
               break;
            end
         end
      end else begin
         // fold into the lower half turn, mirror back at the end
         fold = m > 32'h8000_0000;
         mm = fold ? TURN - longint'(m) : longint'(m);
         e0 = TURN >>> 2;
         for (int k = 0; k < BISECT_COUNT; k++) begin
            stp = (k + 3 < 64) ? (TURN >>> (k + 3)) : 0;
            rot_sincos(e0[31:0], s, c);
            diff = mm - (e0 - ecc_sin(s));
            if (diff > 0) e0 += stp;
            else if (diff < 0) e0 -= stp;
         end
         ea = fold ? 32'(TURN - e0) : e0[31:0];
         iters = BISECT_COUNT;
         conv = 1;
      end
      // half-angle true anomaly
      rot_sincos({1'b0, ea[31:1]}, s, c);
      sp = int_sqrt((64'd65536 + ecc_q) << 16);
      sm = int_sqrt((64'd65536 - ecc_q) << 16);
      y = longint'(sp) * s;
      x = longint'(sm) * c;
      z = vec_angle(y, x);
      res.eccentric_anomaly = ea;
      res.true_anomaly = 32'(2 * z);
      res.converged = conv;
      res.iterations = 7'(iters);
      return res;
   endfunction

   task automatic report(input string field, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      anomaly_type got, want;
      if (reset) begin
         ecc_q <= 16'd0;
         mode_q <= kes_pkg::MODE_NEWTON;
         tol_q <= kes_pkg::TOL_RESET;
         fail_count <= 0;
         outstanding <= 0;
         anomaly_q.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               kes_pkg::REG_ECC:  ecc_q <= csr_pwdata[15:0];
               kes_pkg::REG_MODE: mode_q <= csr_pwdata[0];
               kes_pkg::REG_TOL:  tol_q <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            anomaly_q.push_back(solve_kepler(req_tdata));
            outstanding++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (anomaly_q.size() == 0) begin
               $display("%0t: result beat with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = anomaly_q.pop_front();
               outstanding--;
               if (got.eccentric_anomaly !== want.eccentric_anomaly)
                  report("eccentric_anomaly", got.eccentric_anomaly,
                         want.eccentric_anomaly);
               if (got.true_anomaly !== want.true_anomaly)
                  report("true_anomaly", got.true_anomaly, want.true_anomaly);
               if (got.converged !== want.converged)
                  report("converged", got.converged, want.converged);
               if (got.iterations !== want.iterations)
                  report("iterations", got.iterations, want.iterations);
            end
         end
      end
   end
endmodule

// File: verif/kepler_equation_solver_top_tb.sv
// Testbench top for the Kepler equation solver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module kepler_equation_solver_top_tb;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PHASES      = 6;
   localparam int RANDOM_PER  = 58;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // mean_anomaly
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   // eccentric_anomaly, true_anomaly, converged, iterations
   logic [71:0] rsp_tdata;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          outstanding;
   int          cycles = 0;
   int          burst_left = 0;

   kepler_equation_solver_top dut (.*);

   kepler_equation_solver_checker u_checker (.*);

   always #5 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("kepler_equation_solver_top_tb failed");
         $finish;
      end
   end

   // receiver stalls: alternating open stretches and choppy stretches
   always @(posedge clock) begin
      int phase_cnt;
      phase_cnt = cycles % 4000;
      if (reset) rsp_tready <= 0;
      else if (phase_cnt < 1500) rsp_tready <= 1;
      else if (phase_cnt < 3000) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 7) == 0);
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one beat, with bursts and random gaps
   task automatic send_anomaly(input logic [31:0] m);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_tvalid <= 1;
      req_tdata <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   function automatic logic [31:0] rand_anomaly();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 2000);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 2000);
         2: return 32'h8000_0000 + $urandom_range(0, 4000) - 2000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] edges [10] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0001, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000,
         32'h5555_5555, 32'hAAAA_AAAA};
      logic [15:0] ecc_set [PHASES]  = '{16'd0, 16'd65535, 16'd65535, 16'd32768,
                                          16'd0, 16'd52000};
      logic        mode_set [PHASES] = '{kes_pkg::MODE_NEWTON, kes_pkg::MODE_NEWTON,
                                          ~kes_pkg::MODE_NEWTON, kes_pkg::MODE_NEWTON,
                                          ~kes_pkg::MODE_NEWTON, kes_pkg::MODE_NEWTON};
      logic [15:0] tol_set [PHASES]  = '{kes_pkg::TOL_RESET, 16'd1, 16'd65535, 16'd0,
                                          16'd65535, 16'd300};
      repeat (5) @(posedge clock);
      reset <= 0;
      for (int p = 0; p < PHASES; p++) begin
         // first phase runs on reset values
         if (p > 0) begin
            req_tvalid <= 0;
            wait_drained();
            csr_write(kes_pkg::REG_ECC, {16'h0, ecc_set[p]});
            csr_write(kes_pkg::REG_MODE, {31'h0, mode_set[p]});
            csr_write(kes_pkg::REG_TOL, {16'h0, tol_set[p]});
         end
         foreach (edges[i]) send_anomaly(edges[i]);
         for (int n = 0; n < RANDOM_PER; n++) begin
            // hold off mid-phase once until all results are back
            if (p == 0 && n == RANDOM_PER / 2) begin
               req_tvalid <= 0;
               wait_drained();
            end
            send_anomaly(rand_anomaly());
         end
      end
      req_tvalid <= 0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("kepler_equation_solver_top_tb passed");
      else $display("kepler_equation_solver_top_tb failed");
      $finish;
   end
endmodule
